// File: rtl/core/acmr_pkg.sv
// Shared types, constants and helpers for the audio channel mux router.
`timescale 1ns / 1ps
package acmr_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int MAX_STREAMS  = 4;
  localparam int SAMPLE_BITS  = 32;

  localparam int CH_W     = $clog2(MAX_CHANNELS);
  localparam int CNT_W    = $clog2(MAX_CHANNELS + 1);
  localparam int STREAM_W = 2;
  localparam int KEY_W    = STREAM_W + 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROUTE0       = 3'd0,
    REG_ROUTE1       = 3'd1,
    REG_ROUTE2       = 3'd2,
    REG_ROUTE3       = 3'd3,
    REG_STREAM_COUNT = 3'd4,
    REG_OUT_CH_COUNT = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [STREAM_W-1:0] stream;
    logic [2:0]          chan;
    logic signed [31:0]  sample;
    logic                frame_end;
  } req_t;

  typedef logic [63:0] route_mask_t [MAX_STREAMS];
  typedef logic signed [31:0] frame_t [MAX_CHANNELS];

  // Keep the low SAMPLE_BITS bits and sign extend them.
  function automatic logic signed [31:0] narrow_sample(input logic signed [31:0] raw);
    logic signed [31:0] t;
    t = raw <<< (32 - SAMPLE_BITS);
    return t >>> (32 - SAMPLE_BITS);
  endfunction

endpackage

// File: rtl/core/acmr_route.sv
// Frame store with per-slot write keys; resolves route precedence per request.
`timescale 1ns / 1ps
module acmr_route (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 req_take,
  input  acmr_pkg::req_t       req,
  input  acmr_pkg::route_mask_t route_mask,
  input  logic [2:0]           stream_count,
  output acmr_pkg::frame_t     frame_nxt
);

  logic signed [31:0]       data_r  [acmr_pkg::MAX_CHANNELS];
  logic [acmr_pkg::KEY_W-1:0] key_r [acmr_pkg::MAX_CHANNELS];
  logic [acmr_pkg::MAX_CHANNELS-1:0] written_r;

  logic [3:0]                  streams;
  logic                        active;
  logic [7:0]                  bits;
  logic [acmr_pkg::KEY_W-1:0]  key;
  logic signed [31:0]          sample;
  logic [acmr_pkg::MAX_CHANNELS-1:0] win;

  always_comb begin
    streams = (stream_count > 3'(acmr_pkg::MAX_STREAMS)) ?
              4'(acmr_pkg::MAX_STREAMS) : {1'b0, stream_count};
    active  = ({2'b00, req.stream} < streams) &&
              ({1'b0, req.chan} < 4'(acmr_pkg::MAX_CHANNELS));
    bits    = route_mask[req.stream][{req.chan, 3'b000} +: 8];
    key     = {req.stream, req.chan};
    sample  = acmr_pkg::narrow_sample(req.sample);
    for (int k = 0; k < acmr_pkg::MAX_CHANNELS; k++) begin
      win[k] = req_take && active && bits[k] && (!written_r[k] || key >= key_r[k]);
      frame_nxt[k] = win[k] ? sample : (written_r[k] ? data_r[k] : 32'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (req_take && req.frame_end) begin
      written_r <= '0;
    end else begin
      written_r <= written_r | win;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < acmr_pkg::MAX_CHANNELS; k++) begin
      if (win[k]) begin
        data_r[k] <= sample;
        key_r[k]  <= key;
      end
    end
  end

endmodule

// File: rtl/core/audio_channel_mux_router.sv
// Audio channel mux router top level: config registers, frame store, frame emitter.
// The ending request loads the frame snapshot and emit counter; the output register then
//   takes the first output channel of the frame once the output is not stalled.
// Throughput: one request per cycle; a frame end is held off while the previous
//   frame is still being emitted, min(out_channel_count, 8) channels (0..8), held up by output stalls.
// Reset (rst_n low, synchronous): routes zero, stream_count 1, out_channel_count 2,
//   store empty, no output pending.
`timescale 1ns / 1ps
module audio_channel_mux_router (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [acmr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [acmr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [acmr_pkg::STREAM_W-1:0]      in_stream_index,
  input  logic [2:0]                         in_channel,
  input  logic signed [31:0]                 in_sample,
  input  logic                               in_frame_end,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         out_channel,
  output logic signed [31:0]                 out_sample,
  output logic                               out_frame_last
);

  acmr_pkg::route_mask_t route_mask_r;
  logic [2:0]  stream_count_r;
  logic [3:0]  out_ch_count_r;

  acmr_pkg::req_t   req;
  acmr_pkg::frame_t frame_nxt;
  acmr_pkg::frame_t snap_r;
  logic                       req_take;
  logic [acmr_pkg::CNT_W-1:0] n_r, idx_r, n_clamp;
  logic                       pending, adv;

  logic                       out_valid_r, out_last_r;
  logic [2:0]                 out_ch_r;
  logic signed [31:0]         out_sample_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < acmr_pkg::MAX_STREAMS; s++) route_mask_r[s] <= '0;
      stream_count_r <= 3'd1;
      out_ch_count_r <= 4'd2;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        acmr_pkg::REG_ROUTE0:       route_mask_r[0] <= cfg_wdata;
        acmr_pkg::REG_ROUTE1:       route_mask_r[1] <= cfg_wdata;
        acmr_pkg::REG_ROUTE2:       route_mask_r[2] <= cfg_wdata;
        acmr_pkg::REG_ROUTE3:       route_mask_r[3] <= cfg_wdata;
        acmr_pkg::REG_STREAM_COUNT: stream_count_r  <= cfg_wdata[2:0];
        acmr_pkg::REG_OUT_CH_COUNT: out_ch_count_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  assign pending  = idx_r < n_r;
  assign in_stall = in_frame_end && pending;
  assign req_take = in_valid && !in_stall;
  assign adv      = pending && (!out_valid_r || !out_stall);
  assign n_clamp  = (out_ch_count_r > 4'(acmr_pkg::MAX_CHANNELS)) ?
                    acmr_pkg::CNT_W'(acmr_pkg::MAX_CHANNELS) :
                    acmr_pkg::CNT_W'(out_ch_count_r);

  always_comb begin
    req.stream    = in_stream_index;
    req.chan      = in_channel;
    req.sample    = in_sample;
    req.frame_end = in_frame_end;
  end

  acmr_route u_route (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_take     (req_take),
    .req          (req),
    .route_mask   (route_mask_r),
    .stream_count (stream_count_r),
    .frame_nxt    (frame_nxt)
  );

  // frame snapshot and emit counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r   <= '0;
      idx_r <= '0;
    end else if (req_take && in_frame_end) begin
      n_r   <= n_clamp;
      idx_r <= '0;
    end else if (adv) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take && in_frame_end) begin
      for (int k = 0; k < acmr_pkg::MAX_CHANNELS; k++) snap_r[k] <= frame_nxt[k];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch_r     <= 3'(idx_r[acmr_pkg::CH_W-1:0]);
      out_sample_r <= snap_r[idx_r[acmr_pkg::CH_W-1:0]];
      out_last_r   <= (idx_r + 1'b1) == n_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_channel    = out_ch_r;
  assign out_sample     = out_sample_r;
  assign out_frame_last = out_last_r;

endmodule

// File: rtl/core/acmr_checker.sv
// Port-level checks for the audio channel mux router, bound to the top level.
`timescale 1ns / 1ps
module acmr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [2:0]        out_channel,
  input logic signed [31:0] out_sample,
  input logic              out_frame_last
);

  // stalled output request holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_channel) &&
      $stable(out_sample) && $stable(out_frame_last))
    else $error("stalled output changed");

  // channels of one frame go out back to back in ascending order
  a_out_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_frame_last |=>
      out_valid && (out_channel == 3'($past(out_channel) + 3'd1)))
    else $error("output channel sequence broken");

  // the next frame, when it follows right away, starts at channel 0
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_frame_last |=> !out_valid || (out_channel == 3'd0))
    else $error("next frame does not start at channel 0");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind audio_channel_mux_router acmr_checker u_acmr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_channel    (out_channel),
  .out_sample     (out_sample),
  .out_frame_last (out_frame_last)
);
